// ----- hdl/ilir_pkg.sv -----
`timescale 1ns / 1ps

package ilir_pkg;

  // Default sizing
  localparam int unsigned CAPACITY_DEF  = 256;
  localparam int unsigned WORD_BITS_DEF = 32;

  // Number of taps folded into one first-level read register
  localparam int unsigned READ_GROUP = 16;

  // Fixed field widths of the beats
  localparam int unsigned REQ_W  = 2;
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned LEN_W  = 9;

  typedef enum logic [REQ_W-1:0] {
    REQ_GET    = 2'd0,
    REQ_SET    = 2'd1,
    REQ_INSERT = 2'd2,
    REQ_REMOVE = 2'd3
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_NULL  = 2'd2,
    STAT_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] word;
    logic [LEN_W-1:0]  length;
  } rsp_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic cap;  // capture the read tap
    logic rd;   // the addressed cell drives its old word on the tap
    logic ins;  // open a slot at the index, shift upper entries up
    logic rem;  // close the slot at the index, shift upper entries down
    logic wr;   // overwrite the addressed entry
  } cell_ctrl_t;

endpackage

// ----- hdl/ilir_cell.sv -----
`timescale 1ns / 1ps

module ilir_cell #(
  parameter int unsigned WORD_BITS = ilir_pkg::WORD_BITS_DEF,
  parameter int unsigned POS_W     = 8,
  parameter int unsigned POS       = 0
) (
  input  logic                   clk_i,
  input  ilir_pkg::cell_ctrl_t   ctrl_i,
  input  logic [POS_W-1:0]       index_i,
  input  logic [WORD_BITS-1:0]   value_i,
  input  logic [WORD_BITS-1:0]   prev_i,
  input  logic [WORD_BITS-1:0]   next_i,
  output logic [WORD_BITS-1:0]   word_o,
  output logic [WORD_BITS-1:0]   tap_o
);

  localparam logic [POS_W-1:0] MY_POS = POS_W'(POS);

  logic [WORD_BITS-1:0] word_q, word_d;
  logic [WORD_BITS-1:0] tap_q, tap_d;
  logic                 hit, above;

  assign hit   = (index_i == MY_POS);
  assign above = (MY_POS > index_i);

  // Pick the next entry: shift from a neighbor, take the new word, or hold
  always_comb begin
    word_d = word_q;
    if (ctrl_i.ins) begin
      if (above) begin
        word_d = prev_i;
      end else if (hit) begin
        word_d = value_i;
      end
    end else if (ctrl_i.rem) begin
      if (above || hit) begin
        word_d = next_i;
      end
    end else if (ctrl_i.wr && hit) begin
      word_d = value_i;
    end
  end

  // Drive the old word on the tap only from the addressed cell
  assign tap_d = (ctrl_i.rd && hit) ? word_q : '0;

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    if (ctrl_i.cap) begin
      tap_q <= tap_d;
    end
  end

  assign word_o = word_q;
  assign tap_o  = tap_q;

endmodule

// ----- hdl/ilir_or_tree.sv -----
`timescale 1ns / 1ps

module ilir_or_tree #(
  parameter int unsigned N         = ilir_pkg::CAPACITY_DEF,
  parameter int unsigned WORD_BITS = ilir_pkg::WORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [WORD_BITS-1:0] taps_i [N],
  output logic [WORD_BITS-1:0] word_o
);

  localparam int unsigned GROUP = ilir_pkg::READ_GROUP;
  localparam int unsigned NG    = (N + GROUP - 1) / GROUP;

  logic [WORD_BITS-1:0] part [NG][GROUP];
  logic [WORD_BITS-1:0] grp_d [NG];
  logic [WORD_BITS-1:0] grp_q [NG];

  // Spread the taps into full groups, pad the last one with zeros
  for (genvar g = 0; g < NG; g++) begin : g_grp
    for (genvar j = 0; j < GROUP; j++) begin : g_leaf
      if (g * GROUP + j < N) begin : g_tap
        assign part[g][j] = taps_i[g*GROUP+j];
      end else begin : g_pad
        assign part[g][j] = '0;
      end
    end

    // Fold one group
    always_comb begin
      grp_d[g] = '0;
      for (int j = 0; j < GROUP; j++) begin
        grp_d[g] = grp_d[g] | part[g][j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        grp_q[g] <= grp_d[g];
      end
    end
  end

  // Fold the group registers
  always_comb begin
    word_o = '0;
    for (int g = 0; g < NG; g++) begin
      word_o = word_o | grp_q[g];
    end
  end

endmodule

// ----- hdl/indexed_list_insert_remove.sv -----
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY words, addressed by index.
// Request channel (in_valid_i / in_ready_o / in_data_i): one beat carries a
// get, set, insert or remove with its index and value. Response channel
// (out_valid_o / out_ready_i / out_data_o): one beat per request with the
// status, the read, replaced or removed word, and the new length.
// The entries sit in a row of cells; insert and remove shift every cell above
// the index by one position in the cycle the request is taken.
// The block takes one request at a time: a new request is accepted only in
// the idle state, after the response of the last one has been loaded. The
// read path runs through the capture in the cells, the grouped OR register
// and the final OR into the response register.
// Reset clears the length to zero and empties both channels; entry contents
// are not cleared and are only ever read after an insert has written them.
// When the receiver stalls, the response is held in its register; a following
// request is still taken and waits in the last read stage until the response
// register frees up.
module indexed_list_insert_remove #(
  parameter int unsigned CAPACITY  = ilir_pkg::CAPACITY_DEF,
  parameter int unsigned WORD_BITS = ilir_pkg::WORD_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ilir_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ilir_pkg::rsp_t out_data_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W = $clog2(CAPACITY);
  localparam int unsigned CMP_W = (CNT_W > ilir_pkg::IDX_W) ? CNT_W : ilir_pkg::IDX_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_GROUP,
    S_OUT
  } state_e;

  state_e                      state_q, state_d;
  logic [CNT_W-1:0]            count_q, count_d;
  ilir_pkg::status_e           stat_q, stat_d;
  logic                        out_valid_q, out_valid_d;
  ilir_pkg::rsp_t              out_q, out_d;

  logic                        in_fire, out_load;
  ilir_pkg::req_e              req;
  logic [WORD_BITS-1:0]        val_w;
  logic                        idx_lt, idx_le, is_null, is_full;
  ilir_pkg::cell_ctrl_t        ctrl;
  logic [POS_W-1:0]            cell_idx;
  logic [WORD_BITS-1:0]        words [CAPACITY];
  logic [WORD_BITS-1:0]        taps  [CAPACITY];
  logic [WORD_BITS-1:0]        rd_word;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign req        = ilir_pkg::req_e'(in_data_i.req_type);
  assign val_w      = WORD_BITS'(in_data_i.value);
  assign cell_idx   = POS_W'(in_data_i.index);

  // Check the request against the current length
  assign idx_lt  = CMP_W'(in_data_i.index) <  CMP_W'(count_q);
  assign idx_le  = CMP_W'(in_data_i.index) <= CMP_W'(count_q);
  assign is_null = (val_w == '0);
  assign is_full = (count_q == CAP_CNT);

  // Decode the request into a status and the cell command
  always_comb begin
    stat_d  = ilir_pkg::STAT_OK;
    ctrl    = '0;
    count_d = count_q;
    unique case (req)
      ilir_pkg::REQ_GET: begin
        if (!idx_lt) begin
          stat_d = ilir_pkg::STAT_RANGE;
        end
      end
      ilir_pkg::REQ_SET: begin
        if (!idx_lt) begin
          stat_d = ilir_pkg::STAT_RANGE;
        end else if (is_null) begin
          stat_d = ilir_pkg::STAT_NULL;
        end
      end
      ilir_pkg::REQ_INSERT: begin
        if (!idx_le) begin
          stat_d = ilir_pkg::STAT_RANGE;
        end else if (is_null) begin
          stat_d = ilir_pkg::STAT_NULL;
        end else if (is_full) begin
          stat_d = ilir_pkg::STAT_FULL;
        end
      end
      ilir_pkg::REQ_REMOVE: begin
        if (!idx_lt) begin
          stat_d = ilir_pkg::STAT_RANGE;
        end
      end
      default: begin
        stat_d = ilir_pkg::STAT_RANGE;
      end
    endcase

    ctrl.cap = in_fire;
    if (in_fire && (stat_d == ilir_pkg::STAT_OK)) begin
      ctrl.rd  = (req != ilir_pkg::REQ_INSERT);
      ctrl.ins = (req == ilir_pkg::REQ_INSERT);
      ctrl.rem = (req == ilir_pkg::REQ_REMOVE);
      ctrl.wr  = (req == ilir_pkg::REQ_SET);
      if (ctrl.ins) begin
        count_d = count_q + CNT_W'(1);
      end else if (ctrl.rem) begin
        count_d = count_q - CNT_W'(1);
      end
    end
  end

  // Row of entry cells, each shifting from its neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_BITS-1:0] prev_w, next_w;
    if (i == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_prev
      assign prev_w = words[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_next
      assign next_w = words[i+1];
    end

    ilir_cell #(
      .WORD_BITS (WORD_BITS),
      .POS_W     (POS_W),
      .POS       (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .index_i (cell_idx),
      .value_i (val_w),
      .prev_i  (prev_w),
      .next_i  (next_w),
      .word_o  (words[i]),
      .tap_o   (taps[i])
    );
  end

  // Collect the addressed word from the taps
  ilir_or_tree #(
    .N         (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_or_tree (
    .clk_i  (clk_i),
    .en_i   (state_q == S_GROUP),
    .taps_i (taps),
    .word_o (rd_word)
  );

  // Sequence the read stages and load the response register
  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_GROUP;
        end
      end
      S_GROUP: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_d       = S_IDLE;
          out_valid_d   = 1'b1;
          out_d.status  = stat_q;
          out_d.word    = ilir_pkg::DATA_W'(rd_word);
          out_d.length  = ilir_pkg::LEN_W'(count_q);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the response payload and the decoded status
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (in_fire) begin
      stat_q <= stat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- dv/indexed_list_insert_remove_test.sv -----
`timescale 1ns / 1ps

module indexed_list_insert_remove_test;
  import ilir_pkg::*;

  localparam int unsigned LIST_CAP     = CAPACITY_DEF;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned RANDOM_ITEMS = 1530;

  // Shadow copy of the list; predicts one response per accepted request
  class list_tracker;
    logic [DATA_W-1:0] store [LIST_CAP];
    int unsigned       len;
    rsp_t              due_rsp [$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       n_op [4];
    int unsigned       n_stat [4];
    int unsigned       peak_len;

    function new();
      len      = 0;
      errors   = 0;
      checked  = 0;
      peak_len = 0;
      foreach (n_op[i]) n_op[i] = 0;
      foreach (n_stat[i]) n_stat[i] = 0;
    endfunction

    // Apply one request to the shadow list and queue its response
    function void take_request(req_t r);
      rsp_t              want;
      int unsigned       idx;
      logic [DATA_W-1:0] val;
      idx         = 32'(r.index);
      val         = r.value;
      want.status = STAT_OK;
      want.word   = '0;
      case (req_e'(r.req_type))
        REQ_GET: begin
          if (idx >= len) want.status = STAT_RANGE;
          else want.word = store[idx];
        end
        REQ_SET: begin
          if (idx >= len) want.status = STAT_RANGE;
          else if (val == '0) want.status = STAT_NULL;
          else begin
            want.word  = store[idx];
            store[idx] = val;
          end
        end
        REQ_INSERT: begin
          if (idx > len) want.status = STAT_RANGE;
          else if (val == '0) want.status = STAT_NULL;
          else if (len >= LIST_CAP) want.status = STAT_FULL;
          else begin
            for (int unsigned i = len; i > idx; i--) store[i] = store[i-1];
            store[idx] = val;
            len++;
          end
        end
        default: begin
          if (idx >= len) want.status = STAT_RANGE;
          else begin
            want.word = store[idx];
            for (int unsigned i = idx; i + 1 < len; i++) store[i] = store[i+1];
            len--;
          end
        end
      endcase
      want.length = LEN_W'(len);
      if (len > peak_len) peak_len = len;
      n_op[r.req_type]++;
      n_stat[want.status]++;
      due_rsp.push_back(want);
    endfunction

    // Compare one response beat with the oldest prediction
    function void match_response(rsp_t got);
      rsp_t want;
      if (due_rsp.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: response with none pending: status %0d word %h length %0d",
                   $realtime, got.status, got.word, got.length);
        return;
      end
      want = due_rsp.pop_front();
      checked++;
      if (got.status !== want.status || got.word !== want.word ||
          got.length !== want.length) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch #%0d: want status %0d word %h length %0d, got %0d %h %0d",
                   $realtime, checked, want.status, want.word, want.length,
                   got.status, got.word, got.length);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t out_data_o;

  list_tracker tracker = new();

  // Sender burst state and receiver stall state
  int unsigned burst_left = 0;
  int unsigned hold_left  = 0;
  int unsigned mode_left  = 0;
  int unsigned rx_mode    = 0;
  bit          hold_req   = 1'b0;
  bit          ready_nxt;
  int unsigned cycle_cnt  = 0;

  indexed_list_insert_remove u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Receiver: rotate between stall patterns, honor a requested long hold-off
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = 80;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      ready_nxt = 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 2);
        mode_left = $urandom_range(5, 60);
      end
      mode_left--;
      case (rx_mode)
        0:       ready_nxt = 1'b1;
        1:       ready_nxt = 1'($urandom_range(0, 1));
        default: ready_nxt = ($urandom_range(0, 3) == 0);
      endcase
    end
    out_ready_i <= ready_nxt;
  end

  // Check every response beat
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) tracker.match_response(out_data_o);
  end

  // Watchdog
  initial begin
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d responses pending",
             cycle_cnt, tracker.due_rsp.size());
    $display("indexed_list_insert_remove_test: errors");
    $finish;
  end

  function automatic req_t mk_req(req_e op, int unsigned idx, logic [DATA_W-1:0] val);
    req_t r;
    r.req_type = op;
    r.index    = IDX_W'(idx);
    r.value    = val;
    return r;
  endfunction

  // Random request, weighted toward inserts or removes, mostly in range
  function automatic req_t rand_req(int unsigned ins_pct, int unsigned rem_pct,
                                    int unsigned cur_len);
    req_t        r;
    int unsigned roll;
    int unsigned top;
    int unsigned idx;
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) r.req_type = REQ_INSERT;
    else if (roll < ins_pct + rem_pct) r.req_type = REQ_REMOVE;
    else if ($urandom_range(0, 1)) r.req_type = REQ_GET;
    else r.req_type = REQ_SET;

    top  = (cur_len > 255) ? 255 : cur_len;
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      if (req_e'(r.req_type) == REQ_INSERT) idx = $urandom_range(0, top);
      else idx = (cur_len == 0) ? 0 : $urandom_range(0, cur_len - 1);
    end else if (roll < 90) begin
      idx = $urandom_range(0, 255);
    end else begin
      case ($urandom_range(0, 3))
        0:       idx = 0;
        1:       idx = top;
        2:       idx = (cur_len == 0) ? 0 : cur_len - 1;
        default: idx = 255;
      endcase
    end
    r.index = IDX_W'(idx);

    roll = $urandom_range(0, 99);
    if (roll < 8) r.value = '0;
    else if (roll < 12) r.value = '1;
    else if (roll < 16) r.value = DATA_W'(1) << $urandom_range(0, DATA_W - 1);
    else r.value = $urandom();
    return r;
  endfunction

  // Present one beat and hold it until taken
  task automatic send_req(req_t r);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.take_request(r);
  endtask

  task automatic idle_for(int unsigned n);
    repeat (n) @(negedge clk_i) in_valid_i <= 1'b0;
  endtask

  // Send in bursts separated by random gaps; some bursts run long
  task automatic offer(req_t r);
    if (burst_left == 0) begin
      idle_for($urandom_range(0, 8));
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    send_req(r);
  endtask

  // Stop sending until every response is back
  task automatic drain();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (tracker.due_rsp.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    req_t        seq [$];
    int unsigned n;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed: empty list, range and null checks and their order, ends of the list
    seq.push_back(mk_req(REQ_GET,    0,   32'd5));
    seq.push_back(mk_req(REQ_REMOVE, 0,   32'd5));
    seq.push_back(mk_req(REQ_SET,    0,   32'd5));
    seq.push_back(mk_req(REQ_INSERT, 1,   32'd7));
    seq.push_back(mk_req(REQ_INSERT, 0,   32'd0));
    seq.push_back(mk_req(REQ_INSERT, 0,   32'hFFFF_FFFF));
    seq.push_back(mk_req(REQ_INSERT, 1,   32'd1));
    seq.push_back(mk_req(REQ_INSERT, 0,   32'hA5A5_A5A5));
    seq.push_back(mk_req(REQ_INSERT, 1,   32'h5A5A_5A5A));
    seq.push_back(mk_req(REQ_GET,    0,   32'd0));
    seq.push_back(mk_req(REQ_GET,    3,   32'd0));
    seq.push_back(mk_req(REQ_GET,    4,   32'd0));
    seq.push_back(mk_req(REQ_SET,    2,   32'd0));
    seq.push_back(mk_req(REQ_SET,    2,   32'h8000_0000));
    seq.push_back(mk_req(REQ_SET,    255, 32'hFFFF_FFFF));
    seq.push_back(mk_req(REQ_INSERT, 255, 32'hFFFF_FFFF));
    seq.push_back(mk_req(REQ_INSERT, 4,   32'd0));
    seq.push_back(mk_req(REQ_INSERT, 5,   32'd0));
    seq.push_back(mk_req(REQ_REMOVE, 1,   32'd0));
    seq.push_back(mk_req(REQ_REMOVE, 2,   32'd0));
    seq.push_back(mk_req(REQ_REMOVE, 0,   32'd0));
    seq.push_back(mk_req(REQ_GET,    0,   32'd0));
    seq.push_back(mk_req(REQ_REMOVE, 0,   32'd0));
    seq.push_back(mk_req(REQ_REMOVE, 0,   32'd0));
    foreach (seq[i]) offer(seq[i]);
    drain();

    // Mixed traffic around a short list
    n = 0;
    repeat (350) begin
      if (n == 100) hold_req = 1'b1;
      offer(rand_req(35, 25, tracker.len));
      n++;
    end
    drain();

    // Fill to capacity, then keep pushing inserts into the full list
    n = 0;
    while (tracker.len < LIST_CAP) begin
      if (n == 150) hold_req = 1'b1;
      offer(rand_req(80, 5, tracker.len));
      n++;
    end
    repeat (40) begin
      offer(rand_req(60, 5, tracker.len));
      n++;
    end
    drain();

    // Empty it again
    while (tracker.len > 0) begin
      offer(rand_req(5, 80, tracker.len));
      n++;
    end
    repeat (20) begin
      offer(rand_req(10, 50, tracker.len));
      n++;
    end
    drain();

    // Mixed traffic for the rest
    n += 350;
    while (n < RANDOM_ITEMS) begin
      if (n % 200 == 0) hold_req = 1'b1;
      offer(rand_req(30, 30, tracker.len));
      n++;
    end
    drain();
    repeat (12) @(posedge clk_i);

    $display("requests get/set/insert/remove: %0d/%0d/%0d/%0d, peak length %0d",
             tracker.n_op[REQ_GET], tracker.n_op[REQ_SET], tracker.n_op[REQ_INSERT],
             tracker.n_op[REQ_REMOVE], tracker.peak_len);
    $display("responses ok/range/null/full: %0d/%0d/%0d/%0d, %0d checked, %0d mismatched",
             tracker.n_stat[STAT_OK], tracker.n_stat[STAT_RANGE],
             tracker.n_stat[STAT_NULL], tracker.n_stat[STAT_FULL],
             tracker.checked, tracker.errors);
    if (tracker.due_rsp.size() != 0)
      $display("%0d responses never arrived", tracker.due_rsp.size());
    if (tracker.errors == 0 && tracker.due_rsp.size() == 0) begin
      $display("indexed_list_insert_remove_test: clean");
    end else begin
      $display("indexed_list_insert_remove_test: errors");
    end
    $finish;
  end

endmodule
